>>> sv/thi_pkg.sv
// ---------------------------------------------------------------------------
// thi_pkg
// Shared types, codes and helpers for the timestamped history interpolator.
// ---------------------------------------------------------------------------
package thi_pkg;

   localparam int POS_W       = 24;
   localparam int YAW_W       = 16;
   localparam int TIME_W      = 31;
   localparam int SLOT_TIME_W = 32;
   localparam int ELAPSED_W   = 16;
   localparam int SPACING_W   = 10;
   localparam int FRAC_W      = 17;               // weight, 65536 means 1.0
   localparam int DIFF_W      = SLOT_TIME_W + 1;  // time differences
   localparam int FIELD_W     = POS_W + 1;        // one field, extended
   localparam int PROD_W      = FIELD_W + FRAC_W + 1;

   localparam logic [SPACING_W-1:0] SPACING_RESET = 10'd50;

   localparam logic [1:0] OP_RESET   = 2'd0;
   localparam logic [1:0] OP_STORE   = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;
   localparam logic [1:0] OP_RESTORE = 2'd3;

   localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
   localparam logic [2:0] STATUS_NO_SHIFT = 3'd1;
   localparam logic [2:0] STATUS_INTERP   = 3'd2;
   localparam logic [2:0] STATUS_OLDEST   = 3'd3;
   localparam logic [2:0] STATUS_RESTORED = 3'd4;
   localparam logic [2:0] STATUS_NO_SAVE  = 3'd5;

   localparam logic [2:0] FLD_X        = 3'd0;
   localparam logic [2:0] FLD_Y        = 3'd1;
   localparam logic [2:0] FLD_Z        = 3'd2;
   localparam logic [2:0] FLD_YAW      = 3'd3;
   localparam logic [2:0] FLD_BOX_LOW  = 3'd4;
   localparam logic [2:0] FLD_BOX_HIGH = 3'd5;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic        [YAW_W-1:0] yaw;
      logic signed [POS_W-1:0] box_low;
      logic signed [POS_W-1:0] box_high;
   } pos_type;

   typedef struct packed {
      logic        [1:0]           op;
      logic        [TIME_W-1:0]    level_time;
      logic        [TIME_W-1:0]    previous_time;
      logic        [ELAPSED_W-1:0] elapsed_ms;
      logic                        is_bot;
      logic        [TIME_W-1:0]    query_time;
      logic signed [POS_W-1:0]     live_x;
      logic signed [POS_W-1:0]     live_y;
      logic signed [POS_W-1:0]     live_z;
      logic        [YAW_W-1:0]     live_yaw;
      logic signed [POS_W-1:0]     live_box_low;
      logic signed [POS_W-1:0]     live_box_high;
   } req_type;

   typedef struct packed {
      logic        [2:0]       status;
      logic signed [POS_W-1:0] out_x;
      logic signed [POS_W-1:0] out_y;
      logic signed [POS_W-1:0] out_z;
      logic        [YAW_W-1:0] out_yaw;
      logic signed [POS_W-1:0] out_box_low;
      logic signed [POS_W-1:0] out_box_high;
   } rsp_type;

   function automatic pos_type live_pos(req_type r);
      pos_type p;
      p.x        = r.live_x;
      p.y        = r.live_y;
      p.z        = r.live_z;
      p.yaw      = r.live_yaw;
      p.box_low  = r.live_box_low;
      p.box_high = r.live_box_high;
      return p;
   endfunction

   function automatic rsp_type make_rsp(logic [2:0] status, pos_type p);
      rsp_type r;
      r.status       = status;
      r.out_x        = p.x;
      r.out_y        = p.y;
      r.out_z        = p.z;
      r.out_yaw      = p.yaw;
      r.out_box_low  = p.box_low;
      r.out_box_high = p.box_high;
      return r;
   endfunction

   // yaw is zero extended, the linear fields sign extended
   function automatic logic signed [FIELD_W-1:0] pos_field(pos_type p, logic [2:0] f);
      logic signed [FIELD_W-1:0] v;
      case (f)
         FLD_X:        v = {p.x[POS_W-1], p.x};
         FLD_Y:        v = {p.y[POS_W-1], p.y};
         FLD_Z:        v = {p.z[POS_W-1], p.z};
         FLD_YAW:      v = {{(FIELD_W-YAW_W){1'b0}}, p.yaw};
         FLD_BOX_LOW:  v = {p.box_low[POS_W-1], p.box_low};
         FLD_BOX_HIGH: v = {p.box_high[POS_W-1], p.box_high};
         default:      v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> sv/thi_stream_if.sv
// ---------------------------------------------------------------------------
// thi_stream_if
// Valid/ready channel carrying one payload struct per transfer.
// ---------------------------------------------------------------------------
interface thi_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> sv/thi_frac_div.sv
// ---------------------------------------------------------------------------
// thi_frac_div
// Restoring divider for the interpolation weight: floor(num * 65536 / den),
// one quotient bit a cycle. Needs num <= den and den > 0.
// ---------------------------------------------------------------------------
module thi_frac_div import thi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIFF_W-1:0] num,
   input  logic [DIFF_W-1:0] den,
   output logic              busy,
   output logic [FRAC_W-1:0] quot
);

   localparam int CNT_W = $clog2(FRAC_W + 1);

   logic [DIFF_W:0]   rem_ff;
   logic [DIFF_W-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic [FRAC_W-1:0] quot_ff;

   logic              ge;
   logic [DIFF_W:0]   diff;

   assign ge   = rem_ff >= {1'b0, den_ff};
   assign diff = ge ? rem_ff - {1'b0, den_ff} : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(FRAC_W);
         rem_ff  <= {1'b0, num};
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         // remainder stays below den, so the shifted value fits
         rem_ff  <= {diff[DIFF_W-1:0], 1'b0};
         quot_ff <= {quot_ff[FRAC_W-2:0], ge};
         cnt_ff  <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

>>> sv/timestamped_history_interpolator.sv
// ---------------------------------------------------------------------------
// timestamped_history_interpolator
// Ring of timestamped positions with an interpolating time shift.
// ---------------------------------------------------------------------------
// One item is worked on at a time; the request side is ready only when the
// sequencer is idle, and a finished result waits in the output register while
// the next request is taken. A restore goes from idle straight to the output
// state, a store passes through a read, a check and a write state, and a
// history reset writes one slot per fill step. A query reads and compares one
// slot at a time (the slot memories have one registered read port) until it
// finds its slot pair. An interpolation then works out the weight in the
// bit-serial divider, which starts on the last compare, while the two position
// reads run under it. After that each field passes through the one shared
// multiplier in a multiply and an add state, and the output register is loaded.
// Slot contents are undefined until the first history reset.
module timestamped_history_interpolator import thi_pkg::*; #(
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   thi_stream_if.sink           req_ch,
   thi_stream_if.source         rsp_ch,
   input  logic                 csr_write_en,
   input  logic [SPACING_W-1:0] csr_write_data
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HISTORY_DEPTH - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_FILL, S_ST_RD, S_ST_CHK, S_ST_WR, S_Q_RD, S_Q_CMP,
      S_PK_RD, S_PK_GET, S_PJ_RD, S_PJ_GET, S_DIV, S_MUL, S_ADD,
      S_OLD_RD, S_OLD_GET, S_OUT
   } state_type;

   state_type                state_ff;
   logic [SPACING_W-1:0]     spacing_ff;
   logic [IDX_W-1:0]         head_ff;
   logic [IDX_W-1:0]         j_ff;
   logic [IDX_W-1:0]         k_ff;
   logic [IDX_W-1:0]         addr_ff;
   logic [IDX_W-1:0]         cnt_ff;
   req_type                  in_ff;
   logic [TIME_W-1:0]        t_ff;
   logic signed [SLOT_TIME_W-1:0] acc_ff;
   logic signed [SLOT_TIME_W-1:0] tk_ff;
   logic [SLOT_TIME_W-1:0]   saved_time_ff;
   pos_type                  saved_pos_ff;
   pos_type                  pk_ff;
   pos_type                  pj_ff;
   pos_type                  res_pos_ff;
   logic [2:0]               res_status_ff;
   logic [FRAC_W-1:0]        frac_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [2:0]               fld_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   // slot memories
   logic [SLOT_TIME_W-1:0] frame_mem  [HISTORY_DEPTH];
   logic [SLOT_TIME_W-1:0] sample_mem [HISTORY_DEPTH];
   pos_type                pos_mem    [HISTORY_DEPTH];
   logic [SLOT_TIME_W-1:0] frame_rd_ff;
   logic [SLOT_TIME_W-1:0] sample_rd_ff;
   pos_type                pos_rd_ff;

   logic                   frame_we, sample_we, pos_we;
   logic [IDX_W-1:0]       frame_wa, sample_wa, pos_wa;
   logic [SLOT_TIME_W-1:0] frame_wd, sample_wd;
   pos_type                pos_wd;

   logic [SLOT_TIME_W-1:0] lt_ext;
   logic [SLOT_TIME_W-1:0] st_sum;
   logic [SLOT_TIME_W-1:0] nt_raw;
   logic [SLOT_TIME_W-1:0] nt;
   logic                   frame_older;
   logic                   sample_hit;
   logic                   save_needed;
   logic [IDX_W-1:0]       head_inc;
   logic [IDX_W-1:0]       j_dec;
   pos_type                live_ff_pos;

   logic signed [FIELD_W-1:0] pk_f, pj_f, d_lin;
   logic signed [FIELD_W-1:0] d_sel;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  sum;

   logic              div_start;
   logic [DIFF_W-1:0] div_num, div_den;
   logic              div_busy;
   logic [FRAC_W-1:0] div_quot;

   req_type           req_p;
   logic [TIME_W-1:0] q_clamped;

   assign req_p       = req_ch.payload;
   assign q_clamped   = (req_p.query_time > req_p.level_time) ?
                        req_p.level_time : req_p.query_time;
   assign live_ff_pos = live_pos(in_ff);
   assign lt_ext      = {1'b0, in_ff.level_time};
   assign head_inc    = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign j_dec       = (j_ff == '0) ? LAST_SLOT : j_ff - 1'b1;
   assign frame_older = $signed(frame_rd_ff) < $signed(lt_ext);
   assign sample_hit  = $signed(sample_rd_ff) <= $signed({1'b0, t_ff});
   assign save_needed = saved_time_ff != lt_ext;

   // sample time of a store
   always_comb begin
      st_sum = {1'b0, in_ff.previous_time} + SLOT_TIME_W'(in_ff.elapsed_ms);
      if (in_ff.is_bot) begin
         nt_raw = lt_ext;
      end else if (st_sum > lt_ext) begin
         nt_raw = lt_ext;
      end else if (st_sum <= {1'b0, in_ff.previous_time}) begin
         nt_raw = {1'b0, in_ff.previous_time} + 1'b1;
      end else begin
         nt_raw = st_sum;
      end
      nt = nt_raw[SLOT_TIME_W-1] ? {1'b0, {(SLOT_TIME_W-1){1'b1}}} : nt_raw;
   end

   // memory write ports
   always_comb begin
      frame_we  = 1'b0;
      sample_we = 1'b0;
      pos_we    = 1'b0;
      frame_wa  = head_ff;
      sample_wa = head_ff;
      pos_wa    = head_ff;
      frame_wd  = lt_ext;
      sample_wd = nt;
      pos_wd    = live_ff_pos;
      case (state_ff)
         S_FILL: begin
            frame_we  = 1'b1;
            sample_we = 1'b1;
            pos_we    = 1'b1;
            frame_wa  = cnt_ff;
            sample_wa = cnt_ff;
            pos_wa    = cnt_ff;
            frame_wd  = acc_ff;
            sample_wd = acc_ff;
         end
         S_ST_CHK: begin
            // closing the old head slot on a new frame
            sample_we = frame_older;
            sample_wd = {1'b0, in_ff.previous_time};
         end
         S_ST_WR: begin
            frame_we  = 1'b1;
            sample_we = 1'b1;
            pos_we    = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_wa] <= frame_wd;
      end
      if (sample_we) begin
         sample_mem[sample_wa] <= sample_wd;
      end
      if (pos_we) begin
         pos_mem[pos_wa] <= pos_wd;
      end
      frame_rd_ff  <= frame_mem[addr_ff];
      sample_rd_ff <= sample_mem[addr_ff];
      pos_rd_ff    <= pos_mem[addr_ff];
   end

   // shared lerp datapath
   always_comb begin
      pk_f  = pos_field(pk_ff, fld_ff);
      pj_f  = pos_field(pj_ff, fld_ff);
      d_lin = pj_f - pk_f;
      d_sel = d_lin;
      if (fld_ff == FLD_YAW) begin
         // shortest way round; exactly half a turn keeps its sign
         if (d_lin > FIELD_W'(32768)) begin
            d_sel = d_lin - FIELD_W'(65536);
         end else if (d_lin < -FIELD_W'(32768)) begin
            d_sel = d_lin + FIELD_W'(65536);
         end
      end
      prod_in = PROD_W'(d_sel) * PROD_W'($signed({1'b0, frac_ff}));
      sum     = PROD_W'(pk_f) + ((prod_ff + PROD_W'(32768)) >>> 16);
   end

   assign div_start = (state_ff == S_Q_CMP) && sample_hit && (j_ff != k_ff);
   assign div_num   = DIFF_W'({tk_ff[SLOT_TIME_W-1], tk_ff} - {2'b00, t_ff});
   assign div_den   = DIFF_W'({tk_ff[SLOT_TIME_W-1], tk_ff}
                            - {sample_rd_ff[SLOT_TIME_W-1], sample_rd_ff});

   thi_frac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         spacing_ff    <= SPACING_RESET;
         head_ff       <= LAST_SLOT;
         saved_time_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            spacing_ff <= csr_write_data;
         end
         // in the output state the register is reloaded below instead
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  in_ff <= req_p;
                  unique case (req_p.op)
                     OP_RESET: begin
                        head_ff  <= LAST_SLOT;
                        cnt_ff   <= LAST_SLOT;
                        acc_ff   <= {1'b0, req_p.level_time};
                        state_ff <= S_FILL;
                     end
                     OP_STORE: begin
                        addr_ff  <= head_ff;
                        state_ff <= S_ST_RD;
                     end
                     OP_QUERY: begin
                        t_ff     <= q_clamped;
                        j_ff     <= head_ff;
                        k_ff     <= head_ff;
                        addr_ff  <= head_ff;
                        state_ff <= S_Q_RD;
                     end
                     OP_RESTORE: begin
                        if (saved_time_ff == {1'b0, req_p.level_time}) begin
                           saved_time_ff <= '0;
                           res_status_ff <= STATUS_RESTORED;
                           res_pos_ff    <= saved_pos_ff;
                        end else begin
                           res_status_ff <= STATUS_NO_SAVE;
                           res_pos_ff    <= live_pos(req_p);
                        end
                        state_ff <= S_OUT;
                     end
                     default: ;
                  endcase
               end
            end
            S_FILL: begin
               acc_ff <= acc_ff - $signed({{(SLOT_TIME_W-SPACING_W){1'b0}}, spacing_ff});
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  res_status_ff <= STATUS_ACCEPTED;
                  res_pos_ff    <= '0;
                  state_ff      <= S_OUT;
               end
            end
            S_ST_RD: state_ff <= S_ST_CHK;
            S_ST_CHK: begin
               if (frame_older) begin
                  head_ff <= head_inc;
               end
               state_ff <= S_ST_WR;
            end
            S_ST_WR: begin
               res_status_ff <= STATUS_ACCEPTED;
               res_pos_ff    <= '0;
               state_ff      <= S_OUT;
            end
            S_Q_RD: state_ff <= S_Q_CMP;
            S_Q_CMP: begin
               if (sample_hit) begin
                  if (j_ff == k_ff) begin
                     res_status_ff <= STATUS_NO_SHIFT;
                     res_pos_ff    <= live_ff_pos;
                     state_ff      <= S_OUT;
                  end else begin
                     if (save_needed) begin
                        saved_pos_ff  <= live_ff_pos;
                        saved_time_ff <= lt_ext;
                     end
                     addr_ff  <= k_ff;
                     state_ff <= S_PK_RD;
                  end
               end else begin
                  k_ff  <= j_ff;
                  tk_ff <= $signed(sample_rd_ff);
                  if (j_dec == head_ff) begin
                     // walked the whole ring: take the oldest slot
                     if (save_needed) begin
                        saved_pos_ff  <= live_ff_pos;
                        saved_time_ff <= lt_ext;
                     end
                     addr_ff  <= j_ff;
                     state_ff <= S_OLD_RD;
                  end else begin
                     j_ff     <= j_dec;
                     addr_ff  <= j_dec;
                     state_ff <= S_Q_RD;
                  end
               end
            end
            S_PK_RD: state_ff <= S_PK_GET;
            S_PK_GET: begin
               pk_ff    <= pos_rd_ff;
               addr_ff  <= j_ff;
               state_ff <= S_PJ_RD;
            end
            S_PJ_RD: state_ff <= S_PJ_GET;
            S_PJ_GET: begin
               pj_ff    <= pos_rd_ff;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (!div_busy) begin
                  frac_ff  <= div_quot;
                  fld_ff   <= FLD_X;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               case (fld_ff)
                  FLD_X:        res_pos_ff.x        <= sum[POS_W-1:0];
                  FLD_Y:        res_pos_ff.y        <= sum[POS_W-1:0];
                  FLD_Z:        res_pos_ff.z        <= sum[POS_W-1:0];
                  FLD_YAW:      res_pos_ff.yaw      <= sum[YAW_W-1:0];
                  FLD_BOX_LOW:  res_pos_ff.box_low  <= sum[POS_W-1:0];
                  default:      res_pos_ff.box_high <= sum[POS_W-1:0];
               endcase
               if (fld_ff == FLD_BOX_HIGH) begin
                  res_status_ff <= STATUS_INTERP;
                  state_ff      <= S_OUT;
               end else begin
                  fld_ff   <= fld_ff + 1'b1;
                  state_ff <= S_MUL;
               end
            end
            S_OLD_RD: state_ff <= S_OLD_GET;
            S_OLD_GET: begin
               res_status_ff <= STATUS_OLDEST;
               res_pos_ff    <= pos_rd_ff;
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= make_rsp(res_status_ff, res_pos_ff);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // head never leaves the ring
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_SLOT)
      else $error("head index beyond ring");

   // weight is at most 1.0 once the divider hands it over
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (frac_ff <= FRAC_W'(65536)))
      else $error("interpolation weight above one");

   // lerp never starts on a weight still being worked out
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> !div_busy)
      else $error("lerp started while divider busy");

   // a result is only raised from the output state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

endmodule

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timestamped history interpolator: directed and
// frame-shaped random requests go in, and each response is checked against a
// behavioural predictor of the slot ring, the weighted interpolation and the
// save/restore logic.
// ---------------------------------------------------------------------------
module tb_top;
   import thi_pkg::*;

   localparam int DEPTH      = 16;
   localparam int CYCLE_CAP  = 3000000;
   localparam int SETTLE_CYC = 120;
   localparam int POS_BITS   = $bits(pos_type);
   localparam longint TMAX   = 64'h7FFF_FFFF;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [SPACING_W-1:0] csr_write_data;

   thi_stream_if #(.payload_type(req_type)) req_if ();
   thi_stream_if #(.payload_type(rsp_type)) rsp_if ();

   timestamped_history_interpolator #(.HISTORY_DEPTH(DEPTH)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // predictor state
   longint  frame_t [DEPTH];
   longint  sample_t[DEPTH];
   pos_type slot_pos[DEPTH];
   int      head;
   longint  saved_t;
   pos_type saved_pos;
   logic [SPACING_W-1:0] spacing;

   req_type pending[$];
   rsp_type expected_rsp[$];
   int      errors;
   int      cycles;
   bit      req_taken;
   int      burst_left;
   int      gap_left;
   int      stall_pct;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint lerp_lin(longint a, longint b, longint frac);
      return a + (((b - a) * frac + 32768) >>> 16);
   endfunction

   function automatic longint lerp_yaw(longint a, longint b, longint frac);
      longint d;
      d = b - a;
      if (d > 32768) d -= 65536;
      else if (d < -32768) d += 65536;
      return (a + ((d * frac + 32768) >>> 16)) & 64'hFFFF;
   endfunction

   function automatic pos_type req_pos(req_type r);
      pos_type p;
      p.x = r.live_x;  p.y = r.live_y;  p.z = r.live_z;
      p.yaw = r.live_yaw;  p.box_low = r.live_box_low;  p.box_high = r.live_box_high;
      return p;
   endfunction

   function automatic rsp_type pack_rsp(logic [2:0] st, pos_type p);
      rsp_type o;
      o.status = st;  o.out_x = p.x;  o.out_y = p.y;  o.out_z = p.z;
      o.out_yaw = p.yaw;  o.out_box_low = p.box_low;  o.out_box_high = p.box_high;
      return o;
   endfunction

   function automatic rsp_type shift_history(req_type r);
      longint lt, pt, nt, t, tk, tj, frac;
      int h, j, k;
      pos_type live, pk, pj, res;
      lt = r.level_time;
      pt = r.previous_time;
      live = req_pos(r);
      h = head;
      case (r.op)
         OP_RESET: begin
            head = DEPTH - 1;
            for (int i = 0; i < DEPTH; i++) begin
               slot_pos[DEPTH-1-i] = live;
               frame_t[DEPTH-1-i] = lt - longint'(i) * longint'(spacing);
               sample_t[DEPTH-1-i] = lt - longint'(i) * longint'(spacing);
            end
            return pack_rsp(STATUS_ACCEPTED, '0);
         end
         OP_STORE: begin
            if (frame_t[h] < lt) begin
               sample_t[h] = pt;
               h = (h + 1) % DEPTH;
               head = h;
            end
            if (r.is_bot) nt = lt;
            else begin
               nt = pt + longint'(r.elapsed_ms);
               if (nt > lt) nt = lt;
               else if (nt <= pt) nt = pt + 1;
            end
            if (nt > TMAX) nt = TMAX;
            slot_pos[h] = live;
            frame_t[h] = lt;
            sample_t[h] = nt;
            return pack_rsp(STATUS_ACCEPTED, '0);
         end
         OP_QUERY: begin
            t = (longint'(r.query_time) > lt) ? lt : longint'(r.query_time);
            j = h;
            k = h;
            do begin
               if (sample_t[j] <= t) break;
               k = j;
               j = (j == 0) ? DEPTH - 1 : j - 1;
            end while (j != h);
            if (j == k) return pack_rsp(STATUS_NO_SHIFT, live);
            if (saved_t != lt) begin
               saved_pos = live;
               saved_t = lt;
            end
            if (j == h) return pack_rsp(STATUS_OLDEST, slot_pos[k]);
            tk = sample_t[k];
            tj = sample_t[j];
            frac = ((tk - t) * 65536) / (tk - tj);
            pk = slot_pos[k];
            pj = slot_pos[j];
            res.x        = lerp_lin(pk.x, pj.x, frac);
            res.y        = lerp_lin(pk.y, pj.y, frac);
            res.z        = lerp_lin(pk.z, pj.z, frac);
            res.yaw      = lerp_yaw(longint'(pk.yaw), longint'(pj.yaw), frac);
            res.box_low  = lerp_lin(pk.box_low, pj.box_low, frac);
            res.box_high = lerp_lin(pk.box_high, pj.box_high, frac);
            return pack_rsp(STATUS_INTERP, res);
         end
         default: begin
            if (saved_t == lt) begin
               saved_t = 0;
               return pack_rsp(STATUS_RESTORED, saved_pos);
            end
            return pack_rsp(STATUS_NO_SAVE, live);
         end
      endcase
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending.size() > 0) begin
            req_if.payload <= pending.pop_front();
            req_if.valid <= 1'b1;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result stalls: stall density is redrawn periodically from 0, 20, 60 or 90 percent
   always @(negedge clock) begin
      if (cycles % 256 == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 60;
            default: stall_pct = 90;
         endcase
      end
      rsp_if.ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      rsp_type got, want;
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("** timestamped_history_interpolator: FAILED **");
         $finish;
      end
      if (!reset) begin
         if (csr_write_en) spacing = csr_write_data;
         if (req_if.valid && req_if.ready) begin
            expected_rsp.push_back(shift_history(req_if.payload));
            req_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_rsp.size() == 0) begin
               report("unexpected transfer status", got.status, -1);
            end else begin
               want = expected_rsp.pop_front();
               if (got.status !== want.status) report("status", got.status, want.status);
               if (got.out_x !== want.out_x) report("x", got.out_x, want.out_x);
               if (got.out_y !== want.out_y) report("y", got.out_y, want.out_y);
               if (got.out_z !== want.out_z) report("z", got.out_z, want.out_z);
               if (got.out_yaw !== want.out_yaw) report("yaw", got.out_yaw, want.out_yaw);
               if (got.out_box_low !== want.out_box_low)
                  report("box_low", got.out_box_low, want.out_box_low);
               if (got.out_box_high !== want.out_box_high)
                  report("box_high", got.out_box_high, want.out_box_high);
            end
         end
      end
   end

   function automatic pos_type rand_pos();
      pos_type p;
      p = POS_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(0, 7) == 0) begin
         p.x = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         p.yaw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         p.box_high = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      end
      return p;
   endfunction

   task automatic push_item(logic [1:0] op, longint lt, longint pt, int el, bit bot,
                            longint qt, pos_type p);
      req_type r;
      r.op = op;
      // restore at time zero could read a never-saved position
      r.level_time = (op == OP_RESTORE && lt == 0) ? 31'd1 : lt[TIME_W-1:0];
      r.previous_time = pt[TIME_W-1:0];
      r.elapsed_ms = el[ELAPSED_W-1:0];
      r.is_bot = bot;
      r.query_time = qt[TIME_W-1:0];
      r.live_x = p.x;  r.live_y = p.y;  r.live_z = p.z;  r.live_yaw = p.yaw;
      r.live_box_low = p.box_low;  r.live_box_high = p.box_high;
      pending.push_back(r);
   endtask

   // wait until nothing is queued, driven or outstanding
   task automatic settle();
      while (pending.size() > 0 || req_if.valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_spacing(logic [SPACING_W-1:0] v);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // frames of plausible traffic with a sprinkling of raw noise
   task automatic run_frames(int n_items);
      longint now, prev;
      int sent;
      pos_type p;
      now = $urandom_range(2000, 100000);
      prev = now - 16;
      push_item(OP_RESET, now, prev, 0, 0, 0, rand_pos());
      sent = 1;
      while (sent < n_items) begin
         prev = now;
         now = now + $urandom_range(1, 80);
         repeat ($urandom_range(1, 3)) begin
            push_item(OP_STORE, now, prev, $urandom_range(0, 120), $urandom_range(0, 3) == 0,
                      0, rand_pos());
            sent++;
         end
         repeat ($urandom_range(0, 3)) begin
            p = rand_pos();
            case ($urandom_range(0, 5))
               0: push_item(OP_QUERY, now, prev, 0, 0, now - $urandom_range(0, 1500), p);
               1: push_item(OP_QUERY, now, prev, 0, 0, now + $urandom_range(0, 50), p);
               2: push_item(OP_RESTORE, now, prev, 0, 0, 0, p);
               3: push_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                            1'($urandom), $urandom, p);
               default: push_item(OP_QUERY, now, prev, 0, 0, now - $urandom_range(0, 600), p);
            endcase
            sent++;
         end
         if ($urandom_range(0, 3) == 0) begin
            push_item(OP_RESTORE, now, prev, 0, 0, 0, rand_pos());
            sent++;
         end
         if ($urandom_range(0, 40) == 0) begin
            push_item(OP_RESET, now, prev, 0, 0, 0, rand_pos());
            sent++;
         end
      end
   endtask

   initial begin
      pos_type hi, lo, mid;
      errors = 0;
      cycles = 0;
      req_taken = 1'b0;
      burst_left = 0;
      gap_left = 0;
      stall_pct = 0;
      head = DEPTH - 1;
      saved_t = 0;
      saved_pos = '0;
      spacing = SPACING_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         frame_t[i] = 0;
         sample_t[i] = 0;
         slot_pos[i] = '0;
      end
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      hi = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF};
      lo = '{24'h800000, 24'h800000, 24'h800000, 16'h0000, 24'h800000, 24'h800000};
      mid = '{24'h000100, 24'hFFFF00, 24'h012345, 16'h8000, 24'hFFFFF0, 24'h000040};

      // directed: default spacing
      push_item(OP_RESET, 10000, 9950, 0, 0, 0, hi);
      push_item(OP_RESTORE, 10000, 9950, 0, 0, 0, mid);            // nothing saved
      push_item(OP_STORE, 10050, 10000, 20, 0, 0, lo);             // new frame
      push_item(OP_STORE, 10050, 10000, 0, 0, 0, mid);             // sample at prev + 1
      push_item(OP_STORE, 10100, 10050, 65535, 0, 0, lo);          // clamped to frame time
      push_item(OP_STORE, 10150, 10100, 7, 1, 0, hi);              // bot sample
      push_item(OP_QUERY, 10150, 10100, 0, 0, 2147483647, mid);    // clamp, no shift
      push_item(OP_QUERY, 10150, 10100, 0, 0, 10120, mid);         // interpolated
      push_item(OP_QUERY, 10150, 10100, 0, 0, 10075, lo);          // same frame, no re-save
      push_item(OP_QUERY, 10150, 10100, 0, 0, 0, lo);              // oldest slot
      push_item(OP_QUERY, 10150, 10100, 0, 0, 9300, hi);           // older than every slot
      push_item(OP_RESTORE, 10150, 10100, 0, 0, 0, lo);            // restored
      push_item(OP_RESTORE, 10150, 10100, 0, 0, 0, lo);            // already restored
      push_item(OP_STORE, 2147483647, 2147483647, 0, 0, 0, mid);   // saturating sample time
      push_item(OP_QUERY, 2147483647, 2147483646, 0, 0, 2147483000, hi);
      push_item(OP_RESTORE, 2147483647, 0, 0, 0, 0, mid);
      push_item(OP_RESET, 0, 0, 0, 0, 0, lo);                      // negative slot times
      push_item(OP_STORE, 5, 0, 3, 0, 0, hi);
      push_item(OP_QUERY, 5, 0, 0, 0, 2, mid);
      push_item(OP_QUERY, 5, 0, 0, 0, 0, mid);
      settle();

      // spacing 0: every slot at one time
      write_spacing(10'd0);
      push_item(OP_RESET, 500, 450, 0, 0, 0, mid);
      push_item(OP_QUERY, 500, 450, 0, 0, 499, hi);
      push_item(OP_STORE, 520, 500, 10, 0, 0, lo);
      push_item(OP_QUERY, 520, 500, 0, 0, 505, hi);
      run_frames(250);
      settle();

      write_spacing(10'h3FF);
      run_frames(350);
      settle();

      write_spacing(10'd1);
      run_frames(300);
      settle();

      write_spacing(10'd1000);
      run_frames(300);
      settle();

      write_spacing(SPACING_W'($urandom_range(2, 200)));
      run_frames(400);
      settle();

      if (errors == 0) begin
         $display("** timestamped_history_interpolator: PASSED **");
      end else begin
         $display("** timestamped_history_interpolator: FAILED **");
      end
      $finish;
   end

endmodule

>>> timestamped_history_interpolator.f
sv/thi_pkg.sv
sv/thi_stream_if.sv
sv/thi_frac_div.sv
sv/timestamped_history_interpolator.sv
dv/tb_top.sv
